// ----- rtl/fmmt_pkg.sv -----
// Shared constants, types and tables for the plane-wave translation coefficient pipeline.
`default_nettype none

package fmmt_pkg;

    // Fixed-point constants of the exponential and trigonometric paths.
    localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;
    localparam logic [29:0] LN2_Q30    = 30'd744261118;
    localparam logic [29:0] INV2PI_Q32 = 30'd683565276;
    localparam logic [30:0] HALFPI_Q30 = 31'd1686629713;
    localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
    localparam logic [31:0] SAT_MAX    = 32'h7FFF_FFFF;

    // Series length, root width and stage counts.
    localparam int NUM_TERMS  = 17;
    localparam int EXP_TERMS  = 13;
    localparam int ROOT_BITS  = 25;
    localparam int STEP_DEPTH = 3;
    localparam int SIDE_DELAY = NUM_TERMS * STEP_DEPTH;
    // Input register, sum, root, four front stages, series, three back stages.
    localparam int LATENCY    = 2 + ROOT_BITS + 4 + SIDE_DELAY + 3;

    // Fields of one input item carried alongside the root pipeline.
    typedef struct packed {
        logic [1:0]         dir;
        logic [23:0]        lam;
        logic signed [4:0]  hre;
        logic signed [4:0]  him;
        logic               last;
    } t_side;

    // State of one Taylor series lane.
    typedef struct packed {
        logic [30:0]        term;
        logic [30:0]        r;
        logic signed [33:0] acc0;
        logic signed [33:0] acc1;
    } t_lane;

    // Control carried beside the series lanes to the output stages.
    typedef struct packed {
        logic signed [15:0] n;
        logic [1:0]         q;
        logic               pneg;
        logic               last;
    } t_post;

    // Where a new series term goes.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_ADD0,
        OP_SUB0,
        OP_ADD1,
        OP_SUB1
    } t_op;

    // Reciprocal floor(2^32 / k) for the constant divisors of the series.
    function automatic logic [32:0] f_recip(input logic [4:0] k);
        logic [32:0] m;
        unique case (k)
            5'd1:    m = 33'd4294967296;
            5'd2:    m = 33'd2147483648;
            5'd3:    m = 33'd1431655765;
            5'd4:    m = 33'd1073741824;
            5'd5:    m = 33'd858993459;
            5'd6:    m = 33'd715827882;
            5'd7:    m = 33'd613566756;
            5'd8:    m = 33'd536870912;
            5'd9:    m = 33'd477218588;
            5'd10:   m = 33'd429496729;
            5'd11:   m = 33'd390451572;
            5'd12:   m = 33'd357913941;
            5'd13:   m = 33'd330382099;
            5'd14:   m = 33'd306783378;
            5'd15:   m = 33'd286331153;
            5'd16:   m = 33'd268435456;
            5'd17:   m = 33'd252645135;
            default: m = 33'd4294967296;
        endcase
        return m;
    endfunction

    // The exponential sums its first terms only.
    function automatic t_op f_exp_op(input int k);
        return (k <= EXP_TERMS) ? OP_ADD0 : OP_NONE;
    endfunction

    // Cosine in acc0, sine in acc1, signs repeating every four terms.
    function automatic t_op f_trig_op(input int k);
        t_op op;
        unique case (k % 4)
            0:       op = OP_ADD0;
            1:       op = OP_ADD1;
            2:       op = OP_SUB0;
            default: op = OP_SUB1;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/fmmt_sqrt.sv -----
// Pipelined integer square root, one root bit per stage.
`default_nettype none

module fmmt_sqrt import fmmt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic [48:0]          i_value,
    input  t_side                i_side,
    output logic                 o_vld,
    output logic [ROOT_BITS-1:0] o_root,
    output t_side                o_side
);

    logic [50:0]          r_rem  [ROOT_BITS];
    logic [ROOT_BITS-1:0] r_root [ROOT_BITS];
    logic                 r_vld  [ROOT_BITS];
    t_side                r_side [ROOT_BITS];

    genvar s;
    generate
        for (s = 0; s < ROOT_BITS; s++) begin : g_stage
            localparam int Bit = ROOT_BITS - 1 - s;
            logic [50:0]          p_rem;
            logic [ROOT_BITS-1:0] p_root;
            logic                 p_vld;
            t_side                p_side;
            logic [50:0]          trial;

            // Select the previous stage, or the input for the first stage.
            if (s == 0) begin : g_first
                assign p_rem  = 51'(i_value);
                assign p_root = '0;
                assign p_vld  = i_vld;
                assign p_side = i_side;
            end else begin : g_next
                assign p_rem  = r_rem[s-1];
                assign p_root = r_root[s-1];
                assign p_vld  = r_vld[s-1];
                assign p_side = r_side[s-1];
            end

            // Setting this bit raises the square by root * 2^(bit+1) + 2^(2*bit).
            assign trial = (51'(p_root) << (Bit + 1)) + (51'd1 << (2 * Bit));

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else begin
                    r_vld[s] <= p_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                r_side[s] <= p_side;
                if (p_rem >= trial) begin
                    r_rem[s]  <= p_rem - trial;
                    r_root[s] <= p_root | (ROOT_BITS'(1) << Bit);
                end else begin
                    r_rem[s]  <= p_rem;
                    r_root[s] <= p_root;
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[ROOT_BITS-1];
    assign o_root = r_root[ROOT_BITS-1];
    assign o_side = r_side[ROOT_BITS-1];

endmodule

`default_nettype wire

// ----- rtl/fmmt_step.sv -----
// One Taylor series step: term = ((term * r) >> 30) / k, then accumulate, in three stages.
`default_nettype none

module fmmt_step import fmmt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_vld,
    input  t_lane      i_lane,
    input  logic [4:0] i_k,
    input  t_op        i_op,
    output logic       o_vld,
    output t_lane      o_lane
);

    logic        r1_vld, r2_vld, r3_vld;
    logic [31:0] r1_x, r2_x, r2_q0;
    t_lane       r1_lane, r2_lane, r3_lane;

    logic [61:0]        w_prod;
    logic [64:0]        w_qprod;
    logic [36:0]        w_qk;
    logic [31:0]        w_rem;
    logic [31:0]        w_term;
    logic signed [33:0] w_term_s;
    t_lane              n_lane;

    // Stage one multiplies term by r; stage two scales by the reciprocal of k.
    assign w_prod  = 62'(i_lane.term) * 62'(i_lane.r);
    assign w_qprod = 65'(r1_x) * 65'(f_recip(i_k));

    // Stage three corrects the quotient estimate, which is low by at most one.
    assign w_qk     = 37'(r2_q0) * 37'(i_k);
    assign w_rem    = r2_x - w_qk[31:0];
    assign w_term   = (w_rem >= 32'(i_k)) ? r2_q0 + 32'd1 : r2_q0;
    assign w_term_s = $signed({2'b00, w_term});

    always_comb begin
        n_lane      = r2_lane;
        n_lane.term = w_term[30:0];
        unique case (i_op)
            OP_ADD0: n_lane.acc0 = r2_lane.acc0 + w_term_s;
            OP_SUB0: n_lane.acc0 = r2_lane.acc0 - w_term_s;
            OP_ADD1: n_lane.acc1 = r2_lane.acc1 + w_term_s;
            OP_SUB1: n_lane.acc1 = r2_lane.acc1 - w_term_s;
            default: n_lane      = n_lane;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_x    <= w_prod[61:30];
        r1_lane <= i_lane;
        r2_x    <= r1_x;
        r2_q0   <= w_qprod[63:32];
        r2_lane <= r1_lane;
        r3_lane <= n_lane;
    end

    assign o_vld  = r3_vld;
    assign o_lane = r3_lane;

endmodule

`default_nettype wire

// ----- rtl/fmmt_scale.sv -----
// Scales one product by 2^n with rounding, saturation and sign.
`default_nettype none

module fmmt_scale import fmmt_pkg::*; (
    input  logic [61:0]        i_mag,
    input  logic               i_neg,
    input  logic signed [15:0] i_n,
    output logic signed [31:0] o_part,
    output logic               o_ovf
);

    logic signed [16:0] w_sh;
    logic [5:0]         w_sh6;
    logic [63:0]        w_res;
    logic [31:0]        w_sat;

    assign w_sh  = 17'sd44 - 17'(i_n);
    assign w_sh6 = w_sh[5:0];

    // Shift right with round half away from zero; large exponents saturate.
    always_comb begin
        priority if (i_n >= 16'sd45) begin
            w_res = 64'h8000_0000;
        end else if (w_sh >= 17'sd64) begin
            w_res = '0;
        end else if (w_sh6 == 6'd0) begin
            w_res = 64'(i_mag);
        end else begin
            w_res = (64'(i_mag) + (64'd1 << (w_sh6 - 6'd1))) >> w_sh6;
        end
    end

    // A zero product gives zero without overflow.
    always_comb begin
        o_ovf = 1'b0;
        w_sat = w_res[31:0];
        if (i_mag == '0) begin
            w_sat = '0;
        end else if (w_res > 64'(SAT_MAX)) begin
            o_ovf = 1'b1;
            w_sat = SAT_MAX;
        end
        o_part = i_neg ? -$signed(w_sat) : $signed(w_sat);
    end

endmodule

`default_nettype wire

// ----- rtl/fmm_diagonal_translation_coef.sv -----
// Top level of the plane-wave translation coefficient pipeline.
//
//  channel   signals                                        handshake
//  config    i_cfg_we, i_cfg_wdata (screening beta Q8.16)   write when i_cfg_we
//  node in   i_direction, i_node_lambda, i_offset_*_half,   transfer when i_start and
//            i_last_node                                    not o_busy
//  result    o_coef_re, o_coef_im, o_overflowed, o_last_out one cycle, o_result_stb
//
// A node enters every cycle; o_busy stays low. The path of each node runs through
// the 25 stage square root and the 17 series steps of three stages each, with the
// total held in LATENCY. Reset is synchronous and clears all valid bits and beta.
// The receiver cannot stall, so the pipeline always advances.
`default_nettype none

module fmm_diagonal_translation_coef import fmmt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [23:0]        i_cfg_wdata,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [1:0]         i_direction,
    input  logic [23:0]        i_node_lambda,
    input  logic signed [4:0]  i_offset_re_half,
    input  logic signed [4:0]  i_offset_im_half,
    input  logic               i_last_node,
    output logic               o_result_stb,
    output logic signed [31:0] o_coef_re,
    output logic signed [31:0] o_coef_im,
    output logic               o_overflowed,
    output logic               o_last_out
);

    logic [23:0] r_beta;

    logic        r_a_vld;
    t_side       r_a_side;
    logic [47:0] r_a_lsq, r_a_bsq;
    logic        r_b_vld;
    t_side       r_b_side;
    logic [48:0] r_b_sum;

    logic                 w_sq_vld;
    logic [ROOT_BITS-1:0] w_sq_root;
    t_side                w_sq_side;

    logic signed [5:0] w_ea, w_pa;
    logic [4:0]        w_ea_abs, w_pa_abs;
    logic              r_c_vld, r_c_eneg, r_c_pneg, r_c_last;
    logic [29:0]       r_c_ae;
    logic [28:0]       r_c_ap;

    logic        r_d_vld, r_d_eneg, r_d_pneg, r_d_last;
    logic [60:0] r_d_y;
    logic [48:0] r_d_t;
    logic [58:0] w_tprod;

    logic [13:0]        w_ip;
    logic [46:0]        w_fr, w_frac;
    logic signed [15:0] w_n;
    logic               r_e_vld;
    logic [29:0]        r_e_frac, r_e_low;
    t_post              r_e_post;

    logic [59:0] w_reprod;
    logic [60:0] w_rtprod;
    logic        r_f_vld;
    t_lane       r_f_exp, r_f_trig;
    t_post       r_f_post;

    logic  w_exp_vld  [NUM_TERMS+1];
    logic  w_trig_vld [NUM_TERMS+1];
    t_lane w_exp_lane [NUM_TERMS+1];
    t_lane w_trig_lane[NUM_TERMS+1];
    t_post r_dly      [SIDE_DELAY];

    logic [30:0]        w_c_cl, w_s_cl;
    logic signed [31:0] w_cs, w_sn;
    logic               r_g_vld, r_g_last;
    logic [31:0]        r_g_m;
    logic signed [31:0] r_g_cs, r_g_sn;
    logic signed [15:0] r_g_n;

    logic [30:0]        w_abs_cs, w_abs_sn;
    logic               r_h_vld, r_h_last, r_h_neg_re, r_h_neg_im;
    logic [61:0]        r_h_mre, r_h_mim;
    logic signed [15:0] r_h_n;

    logic signed [31:0] w_part_re, w_part_im;
    logic               w_ovf_re, w_ovf_im;
    logic               r_out_vld, r_out_ovf, r_out_last;
    logic signed [31:0] r_out_re, r_out_im;

    assign o_busy = 1'b0;

    // Screening constant register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta <= '0;
        end else if (i_cfg_we) begin
            r_beta <= i_cfg_wdata;
        end
    end

    // Valid bits of the front and back stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_d_vld   <= 1'b0;
            r_e_vld   <= 1'b0;
            r_f_vld   <= 1'b0;
            r_g_vld   <= 1'b0;
            r_h_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_a_vld   <= i_start && !o_busy;
            r_b_vld   <= r_a_vld;
            r_c_vld   <= w_sq_vld;
            r_d_vld   <= r_c_vld;
            r_e_vld   <= r_d_vld;
            r_f_vld   <= r_e_vld;
            r_g_vld   <= w_exp_vld[NUM_TERMS] && w_trig_vld[NUM_TERMS];
            r_h_vld   <= r_g_vld;
            r_out_vld <= r_h_vld;
        end
    end

    // Squares of lambda and beta, then their sum.
    always_ff @(posedge i_clk) begin
        r_a_side <= '{dir: i_direction, lam: i_node_lambda, hre: i_offset_re_half,
                      him: i_offset_im_half, last: i_last_node};
        r_a_lsq  <= 48'(i_node_lambda) * 48'(i_node_lambda);
        r_a_bsq  <= 48'(r_beta) * 48'(r_beta);
        r_b_side <= r_a_side;
        r_b_sum  <= 49'(r_a_lsq) + 49'(r_a_bsq);
    end

    fmmt_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_b_vld),
        .i_value (r_b_sum),
        .i_side  (r_b_side),
        .o_vld   (w_sq_vld),
        .o_root  (w_sq_root),
        .o_side  (w_sq_side)
    );

    // Direction picks the exponent axis and the phase axis with their signs.
    always_comb begin
        unique case (w_sq_side.dir)
            2'd0: begin
                w_ea = -6'(w_sq_side.hre);
                w_pa = -6'(w_sq_side.him);
            end
            2'd1: begin
                w_ea = -6'(w_sq_side.him);
                w_pa = 6'(w_sq_side.hre);
            end
            2'd2: begin
                w_ea = 6'(w_sq_side.hre);
                w_pa = 6'(w_sq_side.him);
            end
            default: begin
                w_ea = 6'(w_sq_side.him);
                w_pa = -6'(w_sq_side.hre);
            end
        endcase
        w_ea_abs = w_ea[5] ? 5'(-w_ea) : w_ea[4:0];
        w_pa_abs = w_pa[5] ? 5'(-w_pa) : w_pa[4:0];
    end

    // Exponent and phase magnitudes, then scaling to base-2 and turns.
    assign w_tprod = 59'(r_c_ap) * 59'(INV2PI_Q32);

    always_ff @(posedge i_clk) begin
        r_c_ae   <= 30'(w_sq_root) * 30'(w_ea_abs);
        r_c_ap   <= 29'(w_sq_side.lam) * 29'(w_pa_abs);
        r_c_eneg <= w_ea[5];
        r_c_pneg <= w_pa[5];
        r_c_last <= w_sq_side.last;
        r_d_y    <= 61'(r_c_ae) * 61'(LOG2E_Q30);
        r_d_t    <= w_tprod[48:0];
        r_d_eneg <= r_c_eneg;
        r_d_pneg <= r_c_pneg;
        r_d_last <= r_c_last;
    end

    // Split the base-2 exponent into integer and fraction, floor toward minus infinity.
    assign w_ip = r_d_y[60:47];
    assign w_fr = r_d_y[46:0];

    always_comb begin
        priority if (!r_d_eneg) begin
            w_n    = 16'(w_ip);
            w_frac = w_fr;
        end else if (w_fr == '0) begin
            w_n    = -16'(w_ip);
            w_frac = '0;
        end else begin
            w_n    = -16'(w_ip) - 16'sd1;
            w_frac = 47'(48'h8000_0000_0000 - 48'(w_fr));
        end
    end

    assign w_reprod = 60'(r_e_frac) * 60'(LN2_Q30);
    assign w_rtprod = 61'(r_e_low) * 61'(HALFPI_Q30);

    always_ff @(posedge i_clk) begin
        r_e_frac <= w_frac[46:17];
        r_e_low  <= r_d_t[46:17];
        r_e_post <= '{n: w_n, q: r_d_t[48:47], pneg: r_d_pneg, last: r_d_last};
        r_f_exp  <= '{term: ONE_Q30, r: 31'(w_reprod[59:30]),
                      acc0: 34'(ONE_Q30), acc1: '0};
        r_f_trig <= '{term: ONE_Q30, r: w_rtprod[60:30],
                      acc0: 34'(ONE_Q30), acc1: '0};
        r_f_post <= r_e_post;
    end

    // Exponential and sine/cosine series lanes.
    assign w_exp_vld[0]   = r_f_vld;
    assign w_trig_vld[0]  = r_f_vld;
    assign w_exp_lane[0]  = r_f_exp;
    assign w_trig_lane[0] = r_f_trig;

    genvar g;
    generate
        for (g = 0; g < NUM_TERMS; g++) begin : g_term
            fmmt_step u_exp (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_vld   (w_exp_vld[g]),
                .i_lane  (w_exp_lane[g]),
                .i_k     (5'(g + 1)),
                .i_op    (f_exp_op(g + 1)),
                .o_vld   (w_exp_vld[g+1]),
                .o_lane  (w_exp_lane[g+1])
            );
            fmmt_step u_trig (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_vld   (w_trig_vld[g]),
                .i_lane  (w_trig_lane[g]),
                .i_k     (5'(g + 1)),
                .i_op    (f_trig_op(g + 1)),
                .o_vld   (w_trig_vld[g+1]),
                .o_lane  (w_trig_lane[g+1])
            );
        end
    endgenerate

    // Delay line that keeps exponent, quadrant, phase sign and marker beside the lanes.
    always_ff @(posedge i_clk) begin
        r_dly[0] <= r_f_post;
        for (int i = 1; i < SIDE_DELAY; i++) begin
            r_dly[i] <= r_dly[i-1];
        end
    end

    // Clamp sine and cosine to the unit range, rotate into the quadrant, negate sine for a negative phase.
    always_comb begin
        priority if (w_trig_lane[NUM_TERMS].acc0 < 0) begin
            w_c_cl = '0;
        end else if (w_trig_lane[NUM_TERMS].acc0 > 34'(ONE_Q30)) begin
            w_c_cl = ONE_Q30;
        end else begin
            w_c_cl = w_trig_lane[NUM_TERMS].acc0[30:0];
        end
        priority if (w_trig_lane[NUM_TERMS].acc1 < 0) begin
            w_s_cl = '0;
        end else if (w_trig_lane[NUM_TERMS].acc1 > 34'(ONE_Q30)) begin
            w_s_cl = ONE_Q30;
        end else begin
            w_s_cl = w_trig_lane[NUM_TERMS].acc1[30:0];
        end
        unique case (r_dly[SIDE_DELAY-1].q)
            2'd0: begin
                w_cs = $signed(32'(w_c_cl));
                w_sn = $signed(32'(w_s_cl));
            end
            2'd1: begin
                w_cs = -$signed(32'(w_s_cl));
                w_sn = $signed(32'(w_c_cl));
            end
            2'd2: begin
                w_cs = -$signed(32'(w_c_cl));
                w_sn = -$signed(32'(w_s_cl));
            end
            default: begin
                w_cs = $signed(32'(w_s_cl));
                w_sn = -$signed(32'(w_c_cl));
            end
        endcase
        if (r_dly[SIDE_DELAY-1].pneg) begin
            w_sn = -w_sn;
        end
    end

    assign w_abs_cs = r_g_cs[31] ? 31'(-r_g_cs) : r_g_cs[30:0];
    assign w_abs_sn = r_g_sn[31] ? 31'(-r_g_sn) : r_g_sn[30:0];

    // Mantissa times trig value, then the scaled and saturated output register.
    always_ff @(posedge i_clk) begin
        r_g_m      <= w_exp_lane[NUM_TERMS].acc0[31:0];
        r_g_cs     <= w_cs;
        r_g_sn     <= w_sn;
        r_g_n      <= r_dly[SIDE_DELAY-1].n;
        r_g_last   <= r_dly[SIDE_DELAY-1].last;
        r_h_mre    <= 62'(r_g_m) * 62'(w_abs_cs);
        r_h_mim    <= 62'(r_g_m) * 62'(w_abs_sn);
        r_h_neg_re <= r_g_cs[31];
        r_h_neg_im <= r_g_sn[31];
        r_h_n      <= r_g_n;
        r_h_last   <= r_g_last;
        r_out_re   <= w_part_re;
        r_out_im   <= w_part_im;
        r_out_ovf  <= w_ovf_re || w_ovf_im;
        r_out_last <= r_h_last;
    end

    fmmt_scale u_scale_re (
        .i_mag  (r_h_mre),
        .i_neg  (r_h_neg_re),
        .i_n    (r_h_n),
        .o_part (w_part_re),
        .o_ovf  (w_ovf_re)
    );

    fmmt_scale u_scale_im (
        .i_mag  (r_h_mim),
        .i_neg  (r_h_neg_im),
        .i_n    (r_h_n),
        .o_part (w_part_im),
        .o_ovf  (w_ovf_im)
    );

    assign o_result_stb = r_out_vld;
    assign o_coef_re    = r_out_re;
    assign o_coef_im    = r_out_im;
    assign o_overflowed = r_out_ovf;
    assign o_last_out   = r_out_last;

endmodule

`default_nettype wire

// ----- rtl/fmmt_checker.sv -----
// Port-level checker for the translation coefficient pipeline, bound to the top level.
`default_nettype none

module fmmt_checker import fmmt_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cfg_we,
    input logic [23:0]        i_cfg_wdata,
    input logic               i_start,
    input logic               o_busy,
    input logic [1:0]         i_direction,
    input logic [23:0]        i_node_lambda,
    input logic signed [4:0]  i_offset_re_half,
    input logic signed [4:0]  i_offset_im_half,
    input logic               i_last_node,
    input logic               o_result_stb,
    input logic signed [31:0] o_coef_re,
    input logic signed [31:0] o_coef_im,
    input logic               o_overflowed,
    input logic               o_last_out
);

    // Every accepted node yields a result after the fixed latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LATENCY o_result_stb)
        else $error("accepted node gave no result after the pipeline latency");

    // No result appears without a node transfer at the matching cycle.
    a_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_stb |-> $past(i_start && !o_busy, LATENCY))
        else $error("result without a matching node transfer");

    // The last marker leaves with the result of its own node.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_stb |-> (o_last_out == $past(i_last_node, LATENCY)))
        else $error("last marker does not match its node");

    // An overflow flag comes with a part held at the saturation limit.
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_stb && o_overflowed) |->
            (o_coef_re == 32'sh7FFF_FFFF || o_coef_re == -32'sh7FFF_FFFF ||
             o_coef_im == 32'sh7FFF_FFFF || o_coef_im == -32'sh7FFF_FFFF))
        else $error("overflow flagged without a saturated part");

endmodule

bind fmm_diagonal_translation_coef fmmt_checker u_fmmt_checker (.*);

`default_nettype wire
